// ===== rtl/srtq_pkg.sv =====
// Shared types and constants for the sorted table rank query block.
package srtq_pkg;

    // Default number of table entries
    localparam int unsigned TABLE_DEPTH_DEF = 1024;

    // Field widths on the streams
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CNT_W    = 11;
    localparam int unsigned OUT_DATA_W = 24;

    // Item kinds on the input stream
    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2
    } t_opcode;

    // Result kinds on the output stream
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_COUNTS = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_COMPARE,
        S_SHIFT,
        S_PUT,
        S_RESULT
    } t_state;

endpackage

// ===== rtl/sorted_table_rank_query.sv =====
// Top level: sorted value table with insert, clear and rank query by binary search.
//
// The block holds up to TABLE_DEPTH signed 32-bit values in ascending order in one
// synchronous single-read memory and answers one item at a time. Each search step is
// one memory read and one compare, and a search takes at most ceil(log2(count+1))
// steps. A clear, and an insert refused because the table is full, go straight to the
// result. A query runs two binary searches (lower and upper bound). An insert runs one
// search, then moves every entry above the insert point up by one at one entry per
// cycle through the read and write ports, then writes the value. A result that cannot
// enter the output register holds the sequencer until the register frees. The next item
// is taken as soon as the sequencer is idle, even while the previous result still waits
// in the output register.
module sorted_table_rank_query #(
    parameter int unsigned TABLE_DEPTH = srtq_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [srtq_pkg::VALUE_W-1:0]        i_s_tdata,  // [31:0] value
    input  logic [srtq_pkg::OPCODE_W-1:0]       i_s_tuser,  // [1:0] opcode
    // Output stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [srtq_pkg::OUT_DATA_W-1:0]     o_m_tdata,  // [10:0] count_less,
                                                            // [21:11] count_greater, 0 pad
    output logic [srtq_pkg::STATUS_W-1:0]       o_m_tuser   // [1:0] status
);
    import srtq_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned XW = CW + CNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // Control state
    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic               r_out_valid, n_out_valid;

    // Item and search payload
    logic [OPCODE_W-1:0] r_op, n_op;
    logic signed [VALUE_W-1:0] r_value, n_value;
    logic [CW-1:0]      r_lo, n_lo;
    logic [CW-1:0]      r_hi, n_hi;
    logic [CW-1:0]      r_mid, n_mid;
    logic               r_strict, n_strict;
    logic [CW-1:0]      r_lb, n_lb;
    logic [CW-1:0]      r_src, n_src;
    logic               r_wr_pend, n_wr_pend;
    logic [CW-1:0]      r_wr_addr, n_wr_addr;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [CW-1:0]      r_less, n_less;
    logic [CW-1:0]      r_greater, n_greater;

    // Output register
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [CNT_W-1:0]   r_out_less, n_out_less;
    logic [CNT_W-1:0]   r_out_greater, n_out_greater;

    // Memory ports
    logic [VALUE_W-1:0] r_table [TABLE_DEPTH];
    logic [VALUE_W-1:0] r_rd_data;
    logic               w_re;
    logic [AW-1:0]      w_ra;
    logic               w_we;
    logic [AW-1:0]      w_wa;
    logic [VALUE_W-1:0] w_wd;

    logic               w_accept;
    logic               w_go_right;
    logic [XW-1:0]      w_less_x;
    logic [XW-1:0]      w_greater_x;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Search step decision on the entry just read
    always_comb begin
        if (r_strict) begin
            w_go_right = $signed(r_rd_data) <= r_value;
        end else begin
            w_go_right = $signed(r_rd_data) < r_value;
        end
    end

    // Mask counts to the field width
    assign w_less_x    = XW'(r_less);
    assign w_greater_x = XW'(r_greater);

    // Next state, memory controls and result staging
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_out_valid   = r_out_valid;
        n_op          = r_op;
        n_value       = r_value;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_mid         = r_mid;
        n_strict      = r_strict;
        n_lb          = r_lb;
        n_src         = r_src;
        n_wr_pend     = 1'b0;
        n_wr_addr     = r_wr_addr;
        n_status      = r_status;
        n_less        = r_less;
        n_greater     = r_greater;
        n_out_status  = r_out_status;
        n_out_less    = r_out_less;
        n_out_greater = r_out_greater;
        w_re          = 1'b0;
        w_ra          = '0;
        w_we          = 1'b0;
        w_wa          = '0;
        w_wd          = r_value;

        // Drop the output once taken
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op      = i_s_tuser;
                    n_value   = i_s_tdata;
                    n_lo      = '0;
                    n_hi      = r_count;
                    n_status  = ST_DONE;
                    n_less    = '0;
                    n_greater = '0;
                    n_state   = S_RESULT;
                    case (t_opcode'(i_s_tuser))
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_INSERT: begin
                            if (r_count >= DEPTH_C) begin
                                n_status = ST_FULL;
                            end else begin
                                n_strict = 1'b1;
                                n_state  = S_SEARCH;
                            end
                        end
                        OP_QUERY: begin
                            n_strict = 1'b0;
                            n_state  = S_SEARCH;
                        end
                        default: begin
                            n_status = ST_DONE;
                        end
                    endcase
                end
            end

            S_SEARCH: begin
                if (r_lo < r_hi) begin
                    // Read the middle entry
                    n_mid   = r_lo + ((r_hi - r_lo) >> 1);
                    w_re    = 1'b1;
                    w_ra    = n_mid[AW-1:0];
                    n_state = S_COMPARE;
                end else if (r_op == OP_INSERT) begin
                    n_src   = r_count;
                    n_state = S_SHIFT;
                end else if (!r_strict) begin
                    // Lower bound found, start the upper bound
                    n_lb     = r_lo;
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_strict = 1'b1;
                end else begin
                    n_status  = ST_COUNTS;
                    n_less    = r_lb;
                    n_greater = r_count - r_lo;
                    n_state   = S_RESULT;
                end
            end

            S_COMPARE: begin
                if (w_go_right) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_SEARCH;
            end

            S_SHIFT: begin
                // Write back the entry read last cycle one place up
                if (r_wr_pend) begin
                    w_we = 1'b1;
                    w_wa = r_wr_addr[AW-1:0];
                    w_wd = r_rd_data;
                end
                if (r_src > r_lo) begin
                    n_src     = r_src - CW'(1);
                    w_re      = 1'b1;
                    w_ra      = n_src[AW-1:0];
                    n_wr_pend = 1'b1;
                    n_wr_addr = r_src;
                end else if (!r_wr_pend) begin
                    n_state = S_PUT;
                end
            end

            S_PUT: begin
                w_we    = 1'b1;
                w_wa    = r_lo[AW-1:0];
                w_wd    = r_value;
                n_count = r_count + CW'(1);
                n_state = S_RESULT;
            end

            S_RESULT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_status;
                    n_out_less    = w_less_x[CNT_W-1:0];
                    n_out_greater = w_greater_x[CNT_W-1:0];
                    n_state       = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_wr_pend   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_wr_pend   <= n_wr_pend;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_value       <= n_value;
        r_lo          <= n_lo;
        r_hi          <= n_hi;
        r_mid         <= n_mid;
        r_strict      <= n_strict;
        r_lb          <= n_lb;
        r_src         <= n_src;
        r_wr_addr     <= n_wr_addr;
        r_status      <= n_status;
        r_less        <= n_less;
        r_greater     <= n_greater;
        r_out_status  <= n_out_status;
        r_out_less    <= n_out_less;
        r_out_greater <= n_out_greater;
    end

    // Table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_table[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd_data <= r_table[w_ra];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {{(OUT_DATA_W - 2 * CNT_W){1'b0}}, r_out_greater, r_out_less};

endmodule

// ===== rtl/srtq_checker.sv =====
// Port-level checks for the sorted table rank query block, bound to the top level.
module srtq_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                o_s_tready,
    input logic [srtq_pkg::VALUE_W-1:0]        i_s_tdata,
    input logic [srtq_pkg::OPCODE_W-1:0]       i_s_tuser,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [srtq_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input logic [srtq_pkg::STATUS_W-1:0]       o_m_tuser
);
    import srtq_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed or dropped");

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // One item in work at a time: ready drops after each transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while an item is in work");

    // Counts are zero unless the result is a query answer
    a_zero_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ST_COUNTS) |-> (o_m_tdata == '0))
        else $error("nonzero counts on a non-query result");

endmodule

bind sorted_table_rank_query srtq_checker u_srtq_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the sorted table rank query block.
module tb_top;
    import srtq_pkg::*;

    localparam int unsigned DEPTH       = TABLE_DEPTH_DEF;
    localparam int unsigned CYCLE_LIMIT = 10_000_000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned DRAIN       = 64;
    localparam int unsigned PHASE_ITEMS = 40;

    // Opcode with no operation behind it; the block must leave the table alone and answer done
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [VALUE_W-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    less;
        logic [CNT_W-1:0]    greater;
    } t_rank_result;

    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic [VALUE_W-1:0]  value;
        bit                  typed;
        t_rank_result        want;
    } t_probe_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [VALUE_W-1:0]    i_s_tdata;   // [31:0] value
    logic [OPCODE_W-1:0]   i_s_tuser;   // [1:0] opcode
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // [10:0] count_less, [21:11] count_greater, 0 pad
    logic [STATUS_W-1:0]   o_m_tuser;   // [1:0] status

    // Predictor state: held values in ascending order
    int           held_values[$];
    t_rank_result expected_ranks[$];

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    bit          hold_req     = 1'b0;
    bit          hold_taken   = 1'b0;

    int unsigned cycle_count     = 0;
    int unsigned mismatches      = 0;
    int unsigned results_checked = 0;
    int unsigned n_insert        = 0;
    int unsigned n_query         = 0;
    int unsigned n_clear         = 0;
    int unsigned n_unused        = 0;
    int unsigned n_refused       = 0;
    int unsigned peak_fill       = 0;

    // Directed items; typed expectations only where obvious
    t_probe_row probe_rows [25] = '{
        '{OP_QUERY,  32'd0,        1'b1, '{ST_COUNTS, 11'd0, 11'd0}},
        '{OP_QUERY,  VAL_MIN,      1'b1, '{ST_COUNTS, 11'd0, 11'd0}},
        '{OP_INSERT, 32'd5,        1'b1, '{ST_DONE,   11'd0, 11'd0}},
        '{OP_UNUSED, VAL_MAX,      1'b1, '{ST_DONE,   11'd0, 11'd0}},
        '{OP_CLEAR,  32'd0,        1'b1, '{ST_DONE,   11'd0, 11'd0}},
        '{OP_QUERY,  32'd5,        1'b1, '{ST_COUNTS, 11'd0, 11'd0}},
        '{OP_INSERT, VAL_MAX,      1'b1, '{ST_DONE,   11'd0, 11'd0}},
        '{OP_INSERT, VAL_MIN,      1'b1, '{ST_DONE,   11'd0, 11'd0}},
        '{OP_INSERT, 32'd0,        1'b0, '0},
        '{OP_INSERT, 32'd0,        1'b0, '0},
        '{OP_INSERT, VAL_NEG1,     1'b0, '0},
        '{OP_INSERT, 32'd0,        1'b0, '0},
        '{OP_INSERT, VAL_MAX,      1'b0, '0},
        '{OP_INSERT, VAL_MIN,      1'b0, '0},
        '{OP_QUERY,  32'd0,        1'b1, '{ST_COUNTS, 11'd3, 11'd2}},
        '{OP_QUERY,  VAL_MAX,      1'b1, '{ST_COUNTS, 11'd6, 11'd0}},
        '{OP_QUERY,  VAL_MIN,      1'b1, '{ST_COUNTS, 11'd0, 11'd6}},
        '{OP_QUERY,  VAL_NEG1,     1'b1, '{ST_COUNTS, 11'd2, 11'd5}},
        '{OP_QUERY,  32'd1,        1'b0, '0},
        '{OP_QUERY,  32'h5555_5555, 1'b0, '0},
        '{OP_QUERY,  32'hAAAA_AAAA, 1'b0, '0},
        '{OP_UNUSED, 32'h0000_1234, 1'b1, '{ST_DONE,  11'd0, 11'd0}},
        '{OP_QUERY,  32'h7FFF_FFFE, 1'b0, '0},
        '{OP_CLEAR,  32'hFFFF_0000, 1'b1, '{ST_DONE,  11'd0, 11'd0}},
        '{OP_QUERY,  VAL_MIN,      1'b1, '{ST_COUNTS, 11'd0, 11'd0}}
    };

    sorted_table_rank_query #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Compute the result of one item and update the held table
    function automatic t_rank_result predict_rank(input logic [OPCODE_W-1:0] op,
                                                  input logic [VALUE_W-1:0] raw);
        t_rank_result r;
        int           v;
        int           slot;
        int           below;
        int           above;
        r     = '0;
        v     = raw;
        below = 0;
        above = 0;
        case (op)
            OP_CLEAR: begin
                held_values.delete();
            end
            OP_INSERT: begin
                if (held_values.size() >= DEPTH) begin
                    r.status = ST_FULL;
                    n_refused++;
                end else begin
                    // place after any equal values
                    slot = held_values.size();
                    while (slot > 0 && held_values[slot-1] > v) slot--;
                    held_values.insert(slot, v);
                    if (held_values.size() > peak_fill) peak_fill = held_values.size();
                end
            end
            OP_QUERY: begin
                foreach (held_values[i]) begin
                    if (held_values[i] < v) below++;
                    if (held_values[i] > v) above++;
                end
                r.status  = ST_COUNTS;
                r.less    = CNT_W'(below);
                r.greater = CNT_W'(above);
            end
            default: ;
        endcase
        return r;
    endfunction

    // Choose a value: extremes, full range, near held values, or a dense pool
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = VAL_NEG1;
                    3: v = 32'd0;
                    default: v = 32'd1;
                endcase
            end
            1, 2: v = $urandom;
            3, 4: begin
                if (held_values.size() > 0)
                    v = held_values[$urandom_range(held_values.size() - 1)]
                        + $urandom_range(2) - 1;
                else
                    v = $urandom;
            end
            default: v = $urandom_range(40) - 20;
        endcase
        return v;
    endfunction

    // Offer one item on the input stream and wait for its transfer
    task automatic transfer_item(input logic [OPCODE_W-1:0] op,
                                 input logic [VALUE_W-1:0] value);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= value;
        do @(posedge i_clk); while (!o_s_tready);
        case (op)
            OP_CLEAR:  n_clear++;
            OP_INSERT: n_insert++;
            OP_QUERY:  n_query++;
            default:   n_unused++;
        endcase
    endtask

    task automatic offer(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] value);
        transfer_item(op, value);
        expected_ranks.push_back(predict_rank(op, value));
    endtask

    // One burst: optional clear, a run of inserts, then mixed traffic with noise
    task automatic run_burst();
        int unsigned n_load;
        int unsigned n_mix;
        int unsigned pick;
        if ($urandom_range(3) == 0 || held_values.size() > 48)
            offer(OP_CLEAR, $urandom);
        n_load = $urandom_range(40);
        repeat (n_load) offer(OP_INSERT, pick_value());
        n_mix = $urandom_range(1, 24);
        repeat (n_mix) begin
            pick = $urandom_range(99);
            if (pick < 70)      offer(OP_QUERY, pick_value());
            else if (pick < 92) offer(OP_INSERT, pick_value());
            else if (pick < 96) offer(OP_UNUSED, $urandom);
            else                offer(OP_CLEAR, $urandom);
        end
    endtask

    // Fill the table to capacity mostly in ascending order, then probe it full
    task automatic fill_to_capacity();
        logic [VALUE_W-1:0] ramp;
        offer(OP_CLEAR, $urandom);
        repeat (8) offer(OP_INSERT, $urandom);
        ramp = 32'hC000_0000;
        while (held_values.size() < DEPTH) begin
            offer(OP_INSERT, ramp);
            if ($urandom_range(3) != 0) ramp = ramp + $urandom_range(1, 1 << 20);
            if ($urandom_range(63) == 0) offer(OP_QUERY, pick_value());
        end
        offer(OP_INSERT, VAL_MIN);
        offer(OP_INSERT, VAL_MAX);
        offer(OP_INSERT, ramp);
        offer(OP_INSERT, $urandom);
        offer(OP_QUERY, VAL_MIN);
        offer(OP_QUERY, VAL_MAX);
        offer(OP_QUERY, 32'hC000_0000);
        offer(OP_QUERY, ramp);
        repeat (4) offer(OP_QUERY, pick_value());
        offer(OP_UNUSED, $urandom);
        offer(OP_QUERY, 32'd0);
        offer(OP_CLEAR, $urandom);
        offer(OP_QUERY, 32'd0);
    endtask

    // Stimulus: reset, directed table, then random phases
    initial begin
        t_rank_result want;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probe_rows[i]) begin
            transfer_item(probe_rows[i].op, probe_rows[i].value);
            want = predict_rank(probe_rows[i].op, probe_rows[i].value);
            expected_ranks.push_back(probe_rows[i].typed ? probe_rows[i].want : want);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
                default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
            endcase
            begin
                int unsigned start_items;
                start_items = n_insert + n_query + n_clear;
                while (n_insert + n_query + n_clear - start_items < PHASE_ITEMS) begin
                    run_burst();
                    // hold the output off for a long stretch once
                    if (ph == 0) hold_req = 1'b1;
                end
            end
            if (ph == 3) fill_to_capacity();
        end
        i_s_tvalid <= 1'b0;

        while (expected_ranks.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (expected_ranks.size() != 0) begin
            $display("%0t results missing: %0d", $time, expected_ranks.size());
        end
        $display("ran %0d inserts, %0d queries, %0d clears, %0d unused items;",
                 n_insert, n_query, n_clear, n_unused);
        $display("%0d results checked, table peaked at %0d of %0d entries, %0d %s",
                 results_checked, peak_fill, DEPTH, n_refused,
                 "inserts refused when full");
        if (mismatches == 0 && expected_ranks.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Output side: random stalls plus one long hold-off
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else begin
                i_m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_rank_result got;
        t_rank_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status  = o_m_tuser;
            got.less    = o_m_tdata[CNT_W-1:0];
            got.greater = o_m_tdata[2*CNT_W-1:CNT_W];
            if (expected_ranks.size() == 0) begin
                $display("%0t unexpected result: status %0d less %0d greater %0d",
                         $time, got.status, got.less, got.greater);
                mismatches++;
            end else begin
                want = expected_ranks.pop_front();
                results_checked++;
                if (got.status !== want.status || got.less !== want.less
                        || got.greater !== want.greater) begin
                    $display("%0t mismatch: expected status %0d less %0d greater %0d,%s",
                             $time, want.status, want.less, want.greater, "");
                    $display("%0t           got status %0d less %0d greater %0d",
                             $time, got.status, got.less, got.greater);
                    mismatches++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time, expected_ranks.size());
            $display("status: fail");
            $finish;
        end
    end

endmodule

// ===== files.f =====
rtl/srtq_pkg.sv
rtl/sorted_table_rank_query.sv
rtl/srtq_checker.sv
tb/sv/tb_top.sv
